FILE: sv/windowed_mode_sum_perturbation_core_defines.svh
// assertion macros for the perturbation core checker
// expects i_clk and i_rst_n in the scope that uses them
`ifndef WINDOWED_MODE_SUM_PERTURBATION_CORE_DEFINES_SVH
`define WINDOWED_MODE_SUM_PERTURBATION_CORE_DEFINES_SVH

// same-cycle implication
`define WMSP_HOLDS(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("wmsp check failed");

// next-cycle implication
`define WMSP_NEXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("wmsp check failed");

`endif

FILE: sv/wmsp_pkg.sv
// shared types, constants and helpers of the perturbation core
// no dependencies
package wmsp_pkg;

    localparam int MAX_WORDS = 32;
    localparam int FRAC_BITS = 20;
    localparam int IDX_W     = $clog2(MAX_WORDS);
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int WORD_W    = 24;
    localparam int POS_W     = FRAC_BITS + 1;
    localparam int Y2_W      = POS_W + 1;
    localparam int SIN_FB    = 30;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SUM_W     = WORD_W + $clog2(MAX_WORDS / 2);
    localparam int ACC_W     = SUM_W + SIN_FB + 1;
    localparam int DIV_W     = SUM_W + SIN_FB;
    localparam int CFG_W     = POS_W;
    localparam int POLY_LAST = 4;

    localparam logic [1:0] CFG_KIND  = 2'd0;
    localparam logic [1:0] CFG_FRAC  = 2'd1;
    localparam logic [1:0] CFG_WORDS = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_SINE = 2'd1;
    localparam logic [1:0] KIND_CELL = 2'd2;
    localparam logic [1:0] KIND_WAVE = 2'd3;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    localparam logic [MUL_W-1:0] INV2PI  = 32'd683565276;
    localparam logic [MUL_W-1:0] SC1     = 32'd1686629713;
    localparam logic [MUL_W-1:0] SC3     = 32'd693598668;
    localparam logic [MUL_W-1:0] SC5     = 32'd85569306;
    localparam logic [MUL_W-1:0] SC7     = 32'd5026995;
    localparam logic [MUL_W-1:0] SC9     = 32'd172272;
    localparam logic [MUL_W-1:0] SC11    = 32'd3864;
    localparam logic [MUL_W-1:0] Q30_ONE = 32'd1073741824;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic                     func;
        logic [IDX_W-1:0]         word_index;
        logic signed [WORD_W-1:0] word_value;
        logic [POS_W-1:0]         position;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] perturbation;
        logic                     sum_fault;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    // horner coefficients after the degree-11 seed
    function automatic logic [MUL_W-1:0] poly_coef(input logic [2:0] j);
        logic [MUL_W-1:0] c;
        unique case (j)
            3'd0:    c = SC9;
            3'd1:    c = SC7;
            3'd2:    c = SC5;
            3'd3:    c = SC3;
            default: c = SC1;
        endcase
        return c;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_word(input logic neg,
                                                         input logic [DIV_W-1:0] mag);
        logic signed [WORD_W-1:0] v;
        if (neg) begin
            v = (mag >= DIV_W'(WORD_MAX) + 1'b1) ? WORD_MIN : -$signed(mag[WORD_W-1:0]);
        end else begin
            v = (mag > DIV_W'(WORD_MAX)) ? WORD_MAX : $signed(mag[WORD_W-1:0]);
        end
        return v;
    endfunction

endpackage

FILE: sv/wmsp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module wmsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/wmsp_mul.sv
// shared 32x32 unsigned multiplier with registered product
// depends on wmsp_pkg
module wmsp_mul (
    input  logic                         i_clk,
    input  logic [wmsp_pkg::MUL_W-1:0]   i_a,
    input  logic [wmsp_pkg::MUL_W-1:0]   i_b,
    output logic [wmsp_pkg::PROD_W-1:0]  o_prod
);

    logic [wmsp_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= wmsp_pkg::PROD_W'(i_a) * wmsp_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: sv/wmsp_div.sv
// restoring divider, one quotient bit per cycle
// depends on wmsp_pkg
module wmsp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wmsp_pkg::t_div_req          i_req,
    output logic                        o_done,
    output logic [wmsp_pkg::DIV_W-1:0]  o_quot
);

    localparam int W   = wmsp_pkg::DIV_W;
    localparam int C_W = $clog2(W);

    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_dvd;
    logic [W-1:0]   r_dvs;
    logic [C_W-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [W:0]     rem_sh;
    logic [W:0]     diff;

    assign rem_sh = {r_rem, r_dvd[W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
            r_dvd <= {r_dvd[W-2:0], ~diff[W]};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

FILE: sv/windowed_mode_sum_perturbation_core.sv
// top level of the windowed mode-sum perturbation core: sequencer and datapath
// depends on wmsp_pkg, wmsp_ram, wmsp_mul, wmsp_div
//
//  channel   direction  handshake               payload
//  in        input      i_in_valid / o_in_stall  i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_stall o_out_item (t_out_item)
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// a table write leaves the core idle; an evaluate outside the window goes straight to the output state
// sine kinds: bound by the shared multiplier
// (ten products per mode) and the divider
// alternating cells: mostly the divider
// reset is synchronous and active low; the table is not cleared
// a result waits in the output register, the next item is taken meanwhile
module windowed_mode_sum_perturbation_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  wmsp_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output wmsp_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [wmsp_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int IDX_W  = wmsp_pkg::IDX_W;
    localparam int CNT_W  = wmsp_pkg::CNT_W;
    localparam int WORD_W = wmsp_pkg::WORD_W;
    localparam int POS_W  = wmsp_pkg::POS_W;
    localparam int Y2_W   = wmsp_pkg::Y2_W;
    localparam int MUL_W  = wmsp_pkg::MUL_W;
    localparam int PROD_W = wmsp_pkg::PROD_W;
    localparam int SUM_W  = wmsp_pkg::SUM_W;
    localparam int ACC_W  = wmsp_pkg::ACC_W;
    localparam int DIV_W  = wmsp_pkg::DIV_W;
    localparam int FB     = wmsp_pkg::FRAC_BITS;
    localparam int SB     = wmsp_pkg::SIN_FB;

    typedef enum logic [18:0] {
        S_IDLE   = 19'd1 << 0,
        S_SUMRD  = 19'd1 << 1,
        S_SUMACC = 19'd1 << 2,
        S_BRD    = 19'd1 << 3,
        S_BMUL   = 19'd1 << 4,
        S_KMUL   = 19'd1 << 5,
        S_ANG    = 19'd1 << 6,
        S_X2     = 19'd1 << 7,
        S_POLY   = 19'd1 << 8,
        S_SMUL   = 19'd1 << 9,
        S_ACC    = 19'd1 << 10,
        S_DIVGO  = 19'd1 << 11,
        S_DIV    = 19'd1 << 12,
        S_CMUL   = 19'd1 << 13,
        S_CDIVGO = 19'd1 << 14,
        S_CDIV   = 19'd1 << 15,
        S_CRD    = 19'd1 << 16,
        S_CVAL   = 19'd1 << 17,
        S_OUT    = 19'd1 << 18
    } t_state;

    t_state r_state;

    logic [1:0]        r_kind;
    logic [POS_W-1:0]  r_afrac;
    logic [CNT_W-1:0]  r_words;

    logic [Y2_W-1:0]   r_y2_lo;
    logic [Y2_W-1:0]   r_den2;
    logic [CNT_W-1:0]  r_w;
    logic [CNT_W-1:0]  r_m;
    logic [CNT_W-1:0]  r_i;
    logic [MUL_W-1:0]  r_ty;
    logic [IDX_W-1:0]  r_cell;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [ACC_W-1:0] r_acc;
    logic              r_bneg;
    logic [MUL_W-1:0]  r_t;
    logic [SB:0]       r_x;
    logic [SB:0]       r_x2;
    logic              r_quad2;
    logic [WORD_W-1:0] r_a;
    logic              r_sneg;
    logic [2:0]        r_j;
    logic signed [WORD_W-1:0] r_res;
    logic              r_fault;

    logic              r_ovalid;
    wmsp_pkg::t_out_item r_opay;

    // table and shared units
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              ram_we;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;
    wmsp_pkg::t_div_req div_req;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;

    logic              in_acc;
    logic              out_load;

    // window and word count at accept
    logic [POS_W-1:0]  frac;
    logic [Y2_W-1:0]   y2, lo, hi;
    logic              in_window;
    logic [CNT_W-1:0]  w_c;
    logic [CNT_W-1:0]  m_c;

    // per-step datapath values
    logic [WORD_W-1:0] b_mag;
    logic [FB+MUL_W-1:0] t_rnd;
    logic [MUL_W-1:0]  ph;
    logic [SB:0]       x_c;
    logic [MUL_W-1:0]  s_new;
    logic [MUL_W-1:0]  s_raw;
    logic [SB:0]       s_clip;
    logic [WORD_W-1:0] a_mag;
    logic signed [SUM_W-1:0] sum_n;
    logic [SUM_W-1:0]  sum_mag;
    logic [ACC_W-1:0]  acc_mag;
    logic [DIV_W-1:0]  cell_q;
    logic signed [WORD_W-1:0] v_cell;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_load    = (r_state == S_OUT) && (!r_ovalid || !i_out_stall);
    assign ram_we      = in_acc && (i_in_item.func == wmsp_pkg::FUNC_WRITE);

    wmsp_ram #(.WIDTH(WORD_W), .DEPTH(wmsp_pkg::MAX_WORDS)) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(i_in_item.word_index),
        .i_wdata(i_in_item.word_value),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    wmsp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_prod(prod)
    );

    wmsp_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    always_comb begin
        frac      = (r_afrac > POS_W'(1 << FB)) ? POS_W'(1 << FB) : r_afrac;
        y2        = {i_in_item.position, 1'b0};
        lo        = Y2_W'(1 << FB) - Y2_W'(frac);
        hi        = Y2_W'(1 << FB) + Y2_W'(frac);
        in_window = (y2 > lo) && (y2 < hi);
        if (r_words == '0) begin
            w_c = CNT_W'(1);
        end else if (r_words > CNT_W'(wmsp_pkg::MAX_WORDS)) begin
            w_c = CNT_W'(wmsp_pkg::MAX_WORDS);
        end else begin
            w_c = r_words;
        end
        m_c = w_c >> 1;
    end

    always_comb begin
        b_mag   = ram_rdata[WORD_W-1] ? WORD_W'(-$signed(ram_rdata)) : ram_rdata;
        t_rnd   = prod[FB+MUL_W-1:0] + (FB+MUL_W)'(1 << (FB - 1));
        ph      = prod[MUL_W-1:0] + r_t;
        // fold the second and fourth quarter back onto the first
        x_c     = ph[SB] ? ((SB+1)'(wmsp_pkg::Q30_ONE) - {1'b0, ph[SB-1:0]})
                         : {1'b0, ph[SB-1:0]};
        s_raw   = MUL_W'(prod >> SB);
        s_new   = wmsp_pkg::poly_coef(r_j) - s_raw;
        s_clip  = (s_raw > wmsp_pkg::Q30_ONE) ? (SB+1)'(wmsp_pkg::Q30_ONE) : s_raw[SB:0];
        a_mag   = r_a[WORD_W-1] ? WORD_W'(-$signed(r_a)) : r_a;
        sum_n   = r_sum + SUM_W'($signed(ram_rdata));
        sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        cell_q  = (div_quot >= DIV_W'(r_w)) ? DIV_W'(r_w - 1'b1) : div_quot;
        v_cell  = $signed(ram_rdata);
    end

    // operand select for the shared units
    always_comb begin
        mul_a            = '0;
        mul_b            = '0;
        ram_raddr        = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (r_state)
            S_SUMRD: ram_raddr = IDX_W'(r_i);
            S_BRD:   ram_raddr = IDX_W'(r_m + r_i);
            S_BMUL: begin
                mul_a = MUL_W'(b_mag);
                mul_b = wmsp_pkg::INV2PI;
            end
            S_KMUL: begin
                mul_a     = (r_kind == wmsp_pkg::KIND_WAVE) ? MUL_W'(r_i) : MUL_W'(1);
                mul_b     = r_ty;
                ram_raddr = IDX_W'(r_i);
            end
            S_ANG: begin
                mul_a = MUL_W'(x_c);
                mul_b = MUL_W'(x_c);
            end
            S_X2: begin
                mul_a = MUL_W'(prod[2*SB:SB]);
                mul_b = wmsp_pkg::SC11;
            end
            S_POLY: begin
                mul_a = (r_j == 3'(wmsp_pkg::POLY_LAST)) ? MUL_W'(r_x) : MUL_W'(r_x2);
                mul_b = s_new;
            end
            S_SMUL: begin
                mul_a = MUL_W'(a_mag);
                mul_b = MUL_W'(s_clip);
            end
            S_DIVGO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(acc_mag) + (DIV_W'(sum_mag) << (SB - 1));
                div_req.divisor  = DIV_W'(sum_mag) << SB;
            end
            S_CMUL: begin
                mul_a = MUL_W'(r_y2_lo);
                mul_b = MUL_W'(r_w);
            end
            S_CDIVGO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(prod);
                div_req.divisor  = DIV_W'(r_den2);
            end
            S_CRD:   ram_raddr = r_cell;
            default: ;
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= wmsp_pkg::KIND_SINE;
            r_afrac <= POS_W'(1 << FB);
            r_words <= CNT_W'(wmsp_pkg::MAX_WORDS);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wmsp_pkg::CFG_KIND:  r_kind  <= i_cfg_data[1:0];
                wmsp_pkg::CFG_FRAC:  r_afrac <= i_cfg_data;
                wmsp_pkg::CFG_WORDS: r_words <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_item.func == wmsp_pkg::FUNC_EVAL) begin
                        if (!in_window || r_kind == wmsp_pkg::KIND_NONE ||
                            (r_kind != wmsp_pkg::KIND_CELL && m_c == '0)) begin
                            r_state <= S_OUT;
                        end else if (r_kind == wmsp_pkg::KIND_CELL) begin
                            r_state <= S_CMUL;
                        end else begin
                            r_state <= S_SUMRD;
                        end
                    end
                end
                S_SUMRD:  r_state <= S_SUMACC;
                S_SUMACC: begin
                    if (r_i + 1'b1 != r_m) begin
                        r_state <= S_SUMRD;
                    end else if (sum_n == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_BRD;
                    end
                end
                S_BRD:  r_state <= S_BMUL;
                S_BMUL: r_state <= S_KMUL;
                S_KMUL: r_state <= S_ANG;
                S_ANG:  r_state <= S_X2;
                S_X2:   r_state <= S_POLY;
                S_POLY: begin
                    if (r_j == 3'(wmsp_pkg::POLY_LAST)) begin
                        r_state <= S_SMUL;
                    end
                end
                S_SMUL: r_state <= S_ACC;
                S_ACC:  r_state <= (r_i + 1'b1 == r_m) ? S_DIVGO : S_BRD;
                S_DIVGO: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_CMUL:   r_state <= S_CDIVGO;
                S_CDIVGO: r_state <= S_CDIV;
                S_CDIV: begin
                    if (div_done) begin
                        r_state <= S_CRD;
                    end
                end
                S_CRD:  r_state <= S_CVAL;
                S_CVAL: r_state <= S_OUT;
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_y2_lo <= y2 - lo;
                r_den2  <= {frac, 1'b0};
                r_w     <= w_c;
                r_m     <= m_c;
                r_i     <= '0;
                r_sum   <= '0;
                r_acc   <= '0;
                r_ty    <= MUL_W'(i_in_item.position) << (MUL_W - FB);
                r_res   <= '0;
                r_fault <= 1'b0;
            end
            S_SUMACC: begin
                r_sum <= sum_n;
                if (r_i + 1'b1 != r_m) begin
                    r_i <= r_i + 1'b1;
                end else begin
                    r_i     <= '0;
                    r_fault <= (sum_n == '0);
                end
            end
            S_BMUL: r_bneg <= ram_rdata[WORD_W-1];
            S_KMUL: begin
                r_t <= r_bneg ? -t_rnd[FB+MUL_W-1:FB] : t_rnd[FB+MUL_W-1:FB];
            end
            S_ANG: begin
                r_x     <= x_c;
                r_quad2 <= ph[MUL_W-1];
                r_a     <= ram_rdata;
            end
            S_X2: begin
                r_x2 <= prod[2*SB:SB];
                r_j  <= '0;
            end
            S_POLY: r_j <= r_j + 1'b1;
            S_SMUL: r_sneg <= r_a[WORD_W-1] ^ r_quad2;
            S_ACC: begin
                r_acc <= r_sneg ? r_acc - $signed(ACC_W'(prod[ACC_W-2:0]))
                                : r_acc + $signed(ACC_W'(prod[ACC_W-2:0]));
                r_i   <= r_i + 1'b1;
            end
            S_DIV: begin
                if (div_done) begin
                    r_res <= wmsp_pkg::sat_word(r_acc[ACC_W-1] ^ r_sum[SUM_W-1], div_quot);
                end
            end
            S_CDIV: begin
                if (div_done) begin
                    r_cell <= IDX_W'(cell_q);
                end
            end
            S_CVAL: begin
                // odd cells flip sign, the most negative word saturates
                if (r_cell[0]) begin
                    r_res <= (v_cell == wmsp_pkg::WORD_MIN) ? wmsp_pkg::WORD_MAX : -v_cell;
                end else begin
                    r_res <= v_cell;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_opay.perturbation <= r_res;
            r_opay.sum_fault    <= r_fault;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_opay;

endmodule

FILE: sv/wmsp_chk.sv
// port-level checker for the perturbation core, bound to the top level
// depends on wmsp_pkg and the defines header
`include "windowed_mode_sum_perturbation_core_defines.svh"

module wmsp_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input wmsp_pkg::t_in_item          i_in_item,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input wmsp_pkg::t_out_item         o_out_item
);

    `WMSP_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    `WMSP_NEXT(a_eval_busy, i_in_valid && !o_in_stall && i_in_item.func == wmsp_pkg::FUNC_EVAL, o_in_stall)
    `WMSP_NEXT(a_write_free, i_in_valid && !o_in_stall && i_in_item.func == wmsp_pkg::FUNC_WRITE, !o_in_stall)
    `WMSP_HOLDS(a_fault_zero, o_out_valid && o_out_item.sum_fault, o_out_item.perturbation == '0)

endmodule

bind windowed_mode_sum_perturbation_core wmsp_chk u_wmsp_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_item  (i_in_item),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);

FILE: sim/windowed_mode_sum_perturbation_core_test.sv
// self-checking testbench of windowed_mode_sum_perturbation_core
// depends on wmsp_pkg and the core; predicts each result from a bit-true model
`timescale 1ns / 100ps

module windowed_mode_sum_perturbation_core_test;
    import wmsp_pkg::*;

    localparam int SETTLE_CYCLES = 600;
    localparam longint CYCLE_LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic o_in_stall;
    t_in_item in_item = '0;
    logic o_out_valid;
    logic out_stall = 1'b0;
    t_out_item o_out_item;
    logic cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    windowed_mode_sum_perturbation_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall), .i_in_item(in_item),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall), .o_out_item(o_out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow state of the block
    logic signed [WORD_W-1:0] coef_shadow [MAX_WORDS];
    logic [1:0] kind_shadow = KIND_SINE;
    logic [CFG_W-1:0] frac_shadow = CFG_W'(1 << FRAC_BITS);
    logic [5:0] words_shadow = 6'd32;

    t_in_item pending_items[$];
    t_out_item expected_results[$];
    int errors = 0;
    longint cycle_count = 0;
    bit driver_hold = 1'b0;
    int hold_count = 0;
    int long_hold = 0;

    function automatic longint sine_q30(input logic [31:0] p);
        logic [1:0] quad;
        longint unsigned r, x, x2, s;
        quad = p[31:30];
        r = p[29:0];
        x = quad[0] ? 64'(Q30_ONE) - r : r;
        x2 = (x * x) >> 30;
        s = SC11;
        s = SC9 - ((x2 * s) >> 30);
        s = SC7 - ((x2 * s) >> 30);
        s = SC5 - ((x2 * s) >> 30);
        s = SC3 - ((x2 * s) >> 30);
        s = SC1 - ((x2 * s) >> 30);
        s = (x * s) >> 30;
        if (s > Q30_ONE) s = Q30_ONE;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic logic [31:0] radians_to_turns(input logic signed [WORD_W-1:0] b);
        longint unsigned mag, t;
        mag = (b < 0) ? longint'(-longint'(b)) : longint'(b);
        t = (mag * INV2PI + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (b < 0) ? 32'(0) - t[31:0] : t[31:0];
    endfunction

    function automatic logic signed [WORD_W-1:0] sat24(input bit neg,
                                                     input longint unsigned mag);
        if (neg) return (mag >= 64'h800000) ? WORD_MIN : -WORD_W'(mag);
        return (mag > 64'h7FFFFF) ? WORD_MAX : WORD_W'(mag);
    endfunction

    function automatic t_out_item perturbation_at(input logic [POS_W-1:0] pos);
        t_out_item r;
        longint unsigned one, frac, y2, lo, hi, w, m, num, den, cell_no, accm, dd, q;
        longint sum, acc;
        logic signed [WORD_W-1:0] v;
        logic [31:0] ty, k, ph;
        r = '0;
        one = 64'd1 << FRAC_BITS;
        frac = (frac_shadow > one) ? one : frac_shadow;
        y2 = 64'(pos) * 2;
        lo = one - frac;
        hi = one + frac;
        w = words_shadow;
        if (w < 1) w = 1;
        if (w > MAX_WORDS) w = MAX_WORDS;
        if (y2 > lo && y2 < hi) begin
            if (kind_shadow == KIND_CELL) begin
                num = (y2 - lo) * w;
                den = frac * 2;
                cell_no = den ? num / den : 0;
                if (cell_no >= w) cell_no = w - 1;
                v = coef_shadow[cell_no];
                r.perturbation = cell_no[0] ? ((v == WORD_MIN) ? WORD_MAX : -v) : v;
            end else if (kind_shadow == KIND_SINE || kind_shadow == KIND_WAVE) begin
                m = w / 2;
                sum = 0;
                acc = 0;
                ty = 32'(pos) << (32 - FRAC_BITS);
                for (int i = 0; i < m; i++) sum += coef_shadow[i];
                if (m >= 1 && sum == 0) begin
                    r.sum_fault = 1'b1;
                end else if (m >= 1) begin
                    for (int i = 0; i < m; i++) begin
                        k = (kind_shadow == KIND_SINE) ? 32'd1 : 32'(i);
                        ph = k * ty + radians_to_turns(coef_shadow[m + i]);
                        acc += longint'(coef_shadow[i]) * sine_q30(ph);
                    end
                    accm = (acc < 0) ? -acc : acc;
                    dd = ((sum < 0) ? -sum : sum) << 30;
                    q = (accm + dd / 2) / dd;
                    r.perturbation = sat24((acc < 0) != (sum < 0), q);
                end
            end
        end
        return r;
    endfunction

    // driver
    int gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                if (in_item.func == FUNC_WRITE) begin
                    coef_shadow[in_item.word_index] <= in_item.word_value;
                end else begin
                    expected_results.push_back(perturbation_at(in_item.position));
                end
            end
            if (in_valid && o_in_stall) begin
                // hold payload
            end else if (gap > 0) begin
                gap <= gap - 1;
                in_valid <= 1'b0;
            end else if (pending_items.size() > 0 && !driver_hold) begin
                in_item <= pending_items.pop_front();
                in_valid <= 1'b1;
                gap <= (in_valid && !o_in_stall) ? $urandom_range(0, 3) : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item exp_item;
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %h", o_out_item);
                    errors = errors + 1;
                end else begin
                    exp_item = expected_results.pop_front();
                    if (exp_item.perturbation !== o_out_item.perturbation) begin
                        $error("perturbation expected %0d actual %0d",
                               exp_item.perturbation, o_out_item.perturbation);
                        errors = errors + 1;
                    end
                    if (exp_item.sum_fault !== o_out_item.sum_fault) begin
                        $error("sum_fault expected %0b actual %0b",
                               exp_item.sum_fault, o_out_item.sum_fault);
                        errors = errors + 1;
                    end
                end
            end
            if (long_hold > 0) begin
                long_hold <= long_hold - 1;
                out_stall <= 1'b1;
            end else if (hold_count > 0) begin
                hold_count <= hold_count - 1;
                out_stall <= 1'b1;
            end else if (o_out_valid && !out_stall) begin
                hold_count <= $urandom_range(0, 3);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int data);
        @(posedge i_clk);
        cfg_index <= idx;
        cfg_data <= CFG_W'(data);
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_KIND:  kind_shadow = 2'(data);
            CFG_FRAC:  frac_shadow = CFG_W'(data);
            CFG_WORDS: words_shadow = 6'(data);
            default: ;
        endcase
    endtask

    task automatic drain;
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_item table_write(input int idx, input int val);
        t_in_item t;
        t = '0;
        t.func = FUNC_WRITE;
        t.word_index = idx[IDX_W-1:0];
        t.word_value = val[WORD_W-1:0];
        t.position = POS_W'($urandom);
        return t;
    endfunction

    function automatic t_in_item evaluate(input int pos);
        t_in_item t;
        t.func = FUNC_EVAL;
        t.word_index = IDX_W'($urandom);
        t.word_value = WORD_W'($urandom);
        t.position = pos[POS_W-1:0];
        return t;
    endfunction

    function automatic int rand_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 2) + ((1 << FRAC_BITS) - 1);
        if (r == 1) return $urandom_range(0, 3);
        return $urandom_range(0, 1 << FRAC_BITS);
    endfunction

    function automatic int rand_word();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return -8388608;
        if (r == 1) return 8388607;
        return $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
    endfunction

    initial begin
        int kinds [3];
        int words, fr;
        kinds[0] = int'(KIND_SINE);
        kinds[1] = int'(KIND_CELL);
        kinds[2] = int'(KIND_WAVE);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // fill the table before anything reads it
        for (int i = 0; i < MAX_WORDS; i++)
            pending_items.push_back(table_write(i, (i == 0) ? 8388607 : rand_word()));
        pending_items.push_back(table_write(1, -8388608));
        pending_items.push_back(evaluate(0));
        pending_items.push_back(evaluate(1 << (FRAC_BITS - 1)));
        pending_items.push_back(evaluate(1 << FRAC_BITS));
        pending_items.push_back(evaluate(300000));
        drain();
        // directed: cells at both edges and odd cells, zero sum, no modes, kind zero, zero window
        write_reg(CFG_KIND, int'(KIND_CELL));
        write_reg(CFG_WORDS, 4);
        pending_items.push_back(table_write(1, -8388608));
        pending_items.push_back(evaluate(600000));
        pending_items.push_back(evaluate(1048575));
        pending_items.push_back(evaluate(1));
        drain();
        write_reg(CFG_WORDS, 63);   // clamps to 32
        pending_items.push_back(evaluate(1048575));
        drain();
        write_reg(CFG_KIND, int'(KIND_SINE));
        write_reg(CFG_WORDS, 4);
        pending_items.push_back(table_write(0, 5));
        pending_items.push_back(table_write(1, -5));
        pending_items.push_back(evaluate(400000));
        drain();
        write_reg(CFG_WORDS, 1);
        pending_items.push_back(evaluate(500000));
        drain();
        write_reg(CFG_WORDS, 0);
        pending_items.push_back(evaluate(500000));
        drain();
        write_reg(CFG_KIND, int'(KIND_NONE));
        pending_items.push_back(evaluate(500000));
        drain();
        write_reg(CFG_FRAC, 0);
        write_reg(CFG_KIND, int'(KIND_WAVE));
        write_reg(CFG_WORDS, 8);
        pending_items.push_back(evaluate(1 << (FRAC_BITS - 1)));
        drain();
        write_reg(CFG_FRAC, 'h1FFFFF);
        write_reg(2'd3, 'h12345);    // ignored index
        pending_items.push_back(evaluate(1 << (FRAC_BITS - 1)));
        drain();

        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(CFG_KIND, kinds[ph % 3]);
            case (ph % 4)
                0: fr = 1 << FRAC_BITS;
                1: fr = $urandom_range(1, 1 << FRAC_BITS);
                2: fr = $urandom_range(0, 21'h1FFFFF);
                default: fr = $urandom_range(0, 64);
            endcase
            write_reg(CFG_FRAC, fr);
            words = (ph == 5) ? 32 : $urandom_range(1, 10);
            write_reg(CFG_WORDS, words);
            for (int n = 0; n < 95; n++) begin
                if ($urandom_range(0, 3) == 0)
                    pending_items.push_back(table_write($urandom_range(0, 31), rand_word()));
                else
                    pending_items.push_back(evaluate(rand_pos()));
                if (ph == 3 && n == 40) begin
                    while (pending_items.size() > 0) @(posedge i_clk);
                    driver_hold = 1'b1;
                    while (expected_results.size() > 0 || in_valid) @(posedge i_clk);
                    driver_hold = 1'b0;
                end
            end
            if (ph == 7) begin
                @(posedge i_clk);
                long_hold <= 3000;
            end
            drain();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/wmsp_pkg.sv
sv/wmsp_ram.sv
sv/wmsp_mul.sv
sv/wmsp_div.sv
sv/windowed_mode_sum_perturbation_core.sv
sv/wmsp_chk.sv
sim/windowed_mode_sum_perturbation_core_test.sv
